// File: src/tgfc_pkg.sv
// ----------------------------------------------------------------------------
// tgfc_pkg
// Shared constants and types of the terrain grid frustum culler.
// ----------------------------------------------------------------------------
package tgfc_pkg;

   localparam int MAX_COLS    = 1024;
   localparam int MIN_COLS    = 2;
   localparam int COL_W       = $clog2(MAX_COLS);
   localparam int CNT_W       = COL_W + 1;
   localparam int INDEX_BITS  = 20;
   localparam int TRI_W       = 21;
   localparam int NUM_PLANES  = 6;
   localparam int COEF_W      = 16;
   localparam int POS_W       = 16;
   localparam int PROD_W      = 2 * COEF_W;
   localparam int DIST_W      = PROD_W + 3;
   localparam int RADIUS_W    = 15;
   localparam int FRAC_SHIFT  = 14;
   localparam int PLANE_W     = 4 * COEF_W;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_ADDR_W  = 6;
   localparam int CSR_IDX_LSB = 3;

   typedef enum logic [2:0] {
      REG_PLANE_RIGHT  = 3'd0,
      REG_PLANE_LEFT   = 3'd1,
      REG_PLANE_TOP    = 3'd2,
      REG_PLANE_BOTTOM = 3'd3,
      REG_PLANE_FAR    = 3'd4,
      REG_PLANE_NEAR   = 3'd5,
      REG_GRID_COLS    = 3'd6,
      REG_CULL_RADIUS  = 3'd7
   } tgfc_reg_type;

   typedef enum logic {
      PHASE_UPPER = 1'b0,
      PHASE_LOWER = 1'b1
   } tgfc_phase_type;

   // settings the datapath sees; cols is already clamped to the legal range
   typedef struct packed {
      logic [NUM_PLANES-1:0][PLANE_W-1:0] plane;
      logic [CNT_W-1:0]                   cols;
      logic [RADIUS_W-1:0]                radius;
   } tgfc_cfg_type;

   // one classified vertex handed from the front to the back
   typedef struct packed {
      logic                  first;
      logic                  keep_upper;
      logic                  keep_lower;
      logic [INDEX_BITS-1:0] vertex;
      logic [CNT_W-1:0]      cols;
   } tgfc_work_type;

endpackage

// File: src/tgfc_csr.sv
// ----------------------------------------------------------------------------
// tgfc_csr
// Register file: six clip planes, row length and cull radius.
// ----------------------------------------------------------------------------
module tgfc_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [tgfc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [tgfc_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [tgfc_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready,
   output tgfc_pkg::tgfc_cfg_type          cfg
);
   import tgfc_pkg::*;

   logic [NUM_PLANES-1:0][PLANE_W-1:0] plane_ff, plane_in;
   logic [CNT_W-1:0]                   grid_cols_ff, grid_cols_in;
   logic [RADIUS_W-1:0]                cull_radius_ff, cull_radius_in;
   tgfc_reg_type                       idx;
   logic                               wr;

   assign idx    = tgfc_reg_type'(paddr[CSR_ADDR_W-1:CSR_IDX_LSB]);
   assign wr     = psel && penable && pwrite;
   assign pready = 1'b1;

   always_comb begin
      plane_in       = plane_ff;
      grid_cols_in   = grid_cols_ff;
      cull_radius_in = cull_radius_ff;
      if (wr) begin
         case (idx)
            REG_PLANE_RIGHT, REG_PLANE_LEFT, REG_PLANE_TOP,
            REG_PLANE_BOTTOM, REG_PLANE_FAR, REG_PLANE_NEAR: begin
               plane_in[idx] = pwdata[PLANE_W-1:0];
            end
            REG_GRID_COLS: begin
               grid_cols_in = pwdata[CNT_W-1:0];
            end
            REG_CULL_RADIUS: begin
               cull_radius_in = pwdata[RADIUS_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff       <= '0;
         grid_cols_ff   <= CNT_W'(MIN_COLS);
         cull_radius_ff <= '0;
      end else begin
         plane_ff       <= plane_in;
         grid_cols_ff   <= grid_cols_in;
         cull_radius_ff <= cull_radius_in;
      end
   end

   always_comb begin
      case (idx)
         REG_PLANE_RIGHT, REG_PLANE_LEFT, REG_PLANE_TOP,
         REG_PLANE_BOTTOM, REG_PLANE_FAR, REG_PLANE_NEAR: begin
            prdata = CSR_DATA_W'(plane_ff[idx]);
         end
         REG_GRID_COLS: begin
            prdata = CSR_DATA_W'(grid_cols_ff);
         end
         REG_CULL_RADIUS: begin
            prdata = CSR_DATA_W'(cull_radius_ff);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   // out-of-range row lengths are clamped here once
   always_comb begin
      cfg.plane  = plane_ff;
      cfg.radius = cull_radius_ff;
      if (grid_cols_ff < CNT_W'(MIN_COLS)) begin
         cfg.cols = CNT_W'(MIN_COLS);
      end else if (grid_cols_ff > CNT_W'(MAX_COLS)) begin
         cfg.cols = CNT_W'(MAX_COLS);
      end else begin
         cfg.cols = grid_cols_ff;
      end
   end

endmodule

// File: src/tgfc_front.sv
// ----------------------------------------------------------------------------
// tgfc_front
// Accepts vertices, runs the six plane tests, keeps the row flag line and
// decides which triangles of the completed cell survive.
// ----------------------------------------------------------------------------
module tgfc_front (
   input  logic                              clock,
   input  logic                              reset,
   input  tgfc_pkg::tgfc_cfg_type            cfg,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [tgfc_pkg::POS_W-1:0] req_pos_x,
   input  logic signed [tgfc_pkg::POS_W-1:0] req_pos_y,
   input  logic signed [tgfc_pkg::POS_W-1:0] req_pos_z,
   input  logic                              req_first_of_grid,
   input  logic                              q_full,
   output logic                              push,
   output tgfc_pkg::tgfc_work_type           push_data
);
   import tgfc_pkg::*;

   logic adv;
   logic accept;

   // grid walk state, advanced at accept
   logic [COL_W-1:0]      colpos_ff, colpos_in;
   logic                  past_ff, past_in;
   logic [INDEX_BITS-1:0] vcount_ff, vcount_in;
   logic [COL_W-1:0]      col_base, col_cur;
   logic                  past_cur;
   logic [INDEX_BITS-1:0] vcount_cur;
   logic [CNT_W-1:0]      col_next;
   logic                  emit_cur;

   // stage 1: captured vertex
   logic                     s1_valid_ff;
   logic signed [POS_W-1:0]  s1_x_ff, s1_y_ff, s1_z_ff;
   logic                     s1_first_ff, s1_emit_ff;
   logic [COL_W-1:0]         s1_col_ff;
   logic [INDEX_BITS-1:0]    s1_vertex_ff;

   // stage 2: plane products
   logic                     s2_valid_ff;
   logic signed [PROD_W-1:0] s2_prod_ff [NUM_PLANES][3];
   logic                     s2_first_ff, s2_emit_ff;
   logic [COL_W-1:0]         s2_col_ff;
   logic [INDEX_BITS-1:0]    s2_vertex_ff;
   logic signed [DIST_W-1:0] plane_dist [NUM_PLANES];
   logic signed [DIST_W-1:0] limit;
   logic                     inside_all;

   // stage 3: classification
   logic                     s3_valid_ff;
   logic                     s3_inside_ff;
   logic                     s3_first_ff, s3_emit_ff;
   logic [COL_W-1:0]         s3_col_ff;
   logic [INDEX_BITS-1:0]    s3_vertex_ff;

   logic                     row_mem [MAX_COLS];
   logic                     row_rd_ff;
   logic                     byp_hit_ff, byp_data_ff;
   logic                     left_ff, diag_ff;
   logic                     left_use, diag_use, above;
   logic                     keep_upper, keep_lower, need_push;

   // ---------------------------------------------------------------- accept
   always_comb begin
      col_base   = req_first_of_grid ? '0 : colpos_ff;
      past_cur   = req_first_of_grid ? 1'b0 : past_ff;
      vcount_cur = req_first_of_grid ? '0 : vcount_ff;
      col_cur    = ({1'b0, col_base} >= cfg.cols) ? '0 : col_base;
      emit_cur   = past_cur && (col_cur != '0);
      col_next   = {1'b0, col_cur} + CNT_W'(1);
      if (col_next >= cfg.cols) begin
         colpos_in = '0;
         past_in   = 1'b1;
      end else begin
         colpos_in = col_next[COL_W-1:0];
         past_in   = past_cur;
      end
      vcount_in = vcount_cur + INDEX_BITS'(1);
   end

   assign adv       = !(s3_valid_ff && need_push && q_full);
   assign req_stall = !adv;
   assign accept    = req_valid && adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         colpos_ff <= '0;
         past_ff   <= 1'b0;
         vcount_ff <= '0;
      end else if (accept) begin
         colpos_ff <= colpos_in;
         past_ff   <= past_in;
         vcount_ff <= vcount_in;
      end
   end

   // ---------------------------------------------------------- pipe valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // ---------------------------------------------------------- pipe payload
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_x_ff      <= req_pos_x;
         s1_y_ff      <= req_pos_y;
         s1_z_ff      <= req_pos_z;
         s1_first_ff  <= req_first_of_grid;
         s1_emit_ff   <= emit_cur;
         s1_col_ff    <= col_cur;
         s1_vertex_ff <= vcount_cur;

         for (int p = 0; p < NUM_PLANES; p++) begin
            s2_prod_ff[p][0] <= $signed(cfg.plane[p][COEF_W-1:0]) * s1_x_ff;
            s2_prod_ff[p][1] <= $signed(cfg.plane[p][2*COEF_W-1:COEF_W]) * s1_y_ff;
            s2_prod_ff[p][2] <= $signed(cfg.plane[p][3*COEF_W-1:2*COEF_W]) * s1_z_ff;
         end
         s2_first_ff  <= s1_first_ff;
         s2_emit_ff   <= s1_emit_ff;
         s2_col_ff    <= s1_col_ff;
         s2_vertex_ff <= s1_vertex_ff;

         s3_inside_ff <= inside_all;
         s3_first_ff  <= s2_first_ff;
         s3_emit_ff   <= s2_emit_ff;
         s3_col_ff    <= s2_col_ff;
         s3_vertex_ff <= s2_vertex_ff;

         // previous vertex writes the entry this one reads in the same cycle
         byp_hit_ff   <= s3_valid_ff && (s3_col_ff == s2_col_ff);
         byp_data_ff  <= s3_inside_ff;
      end
   end

   // ------------------------------------------------------- plane distances
   // products are Q18.14, so offset and radius move up by the fraction bits
   always_comb begin
      limit      = $signed({{(DIST_W-RADIUS_W-FRAC_SHIFT){1'b0}}, cfg.radius,
                            {FRAC_SHIFT{1'b0}}});
      inside_all = 1'b1;
      for (int p = 0; p < NUM_PLANES; p++) begin
         plane_dist[p] = DIST_W'(s2_prod_ff[p][0]) + DIST_W'(s2_prod_ff[p][1])
                       + DIST_W'(s2_prod_ff[p][2])
                       + (DIST_W'($signed(cfg.plane[p][4*COEF_W-1:3*COEF_W])) <<< FRAC_SHIFT);
         if (plane_dist[p] > limit) begin
            inside_all = 1'b0;
         end
      end
   end

   // -------------------------------------------------------- row flag line
   always_ff @(posedge clock) begin
      if (adv) begin
         if (s3_valid_ff) begin
            row_mem[s3_col_ff] <= s3_inside_ff;
         end
         row_rd_ff <= row_mem[s2_col_ff];
      end
   end

   // -------------------------------------------------------- classification
   always_comb begin
      left_use   = s3_first_ff ? 1'b0 : left_ff;
      diag_use   = s3_first_ff ? 1'b0 : diag_ff;
      above      = byp_hit_ff ? byp_data_ff : row_rd_ff;
      keep_upper = s3_emit_ff && (left_use || s3_inside_ff || above);
      keep_lower = s3_emit_ff && (left_use || above || diag_use);
      need_push  = keep_upper || keep_lower || s3_first_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= 1'b0;
         diag_ff <= 1'b0;
      end else if (adv && s3_valid_ff) begin
         left_ff <= s3_inside_ff;
         diag_ff <= above;
      end
   end

   assign push                 = s3_valid_ff && need_push && !q_full;
   assign push_data.first      = s3_first_ff;
   assign push_data.keep_upper = keep_upper;
   assign push_data.keep_lower = keep_lower;
   assign push_data.vertex     = s3_vertex_ff;
   assign push_data.cols       = cfg.cols;

endmodule

// File: src/tgfc_queue.sv
// ----------------------------------------------------------------------------
// tgfc_queue
// Small queue of classified vertices between the front and the back.
// ----------------------------------------------------------------------------
module tgfc_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  tgfc_pkg::tgfc_work_type push_data,
   output logic                    full,
   input  logic                    pop,
   output logic                    empty,
   output tgfc_pkg::tgfc_work_type head
);
   import tgfc_pkg::*;

   tgfc_work_type       slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;

   assign full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         count_ff <= count_ff + QCNT_W'(push) - QCNT_W'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: src/tgfc_back.sv
// ----------------------------------------------------------------------------
// tgfc_back
// Expands each classified vertex into its kept triangles, one beat a cycle
// while rsp_stall is low, and numbers them.
// ----------------------------------------------------------------------------
module tgfc_back (
   input  logic                                clock,
   input  logic                                reset,
   input  tgfc_pkg::tgfc_work_type             head,
   input  logic                                empty,
   output logic                                pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [tgfc_pkg::INDEX_BITS-1:0]     rsp_corner_a,
   output logic [tgfc_pkg::INDEX_BITS-1:0]     rsp_corner_b,
   output logic [tgfc_pkg::INDEX_BITS-1:0]     rsp_corner_c,
   output logic [tgfc_pkg::TRI_W-1:0]          rsp_tri_number,
   output logic                                rsp_last_of_item
);
   import tgfc_pkg::*;

   tgfc_phase_type        phase_ff, phase_in;
   logic [TRI_W-1:0]      kept_ff, kept_in, kept_base;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [INDEX_BITS-1:0] corner_a_ff, corner_b_ff, corner_c_ff;
   logic [TRI_W-1:0]      tri_number_ff;
   logic                  last_ff;
   logic                  out_free, go, emit_upper, emit_lower, emit;
   logic [INDEX_BITS-1:0] v_left, v_up, v_diag;

   assign v_left = head.vertex - INDEX_BITS'(1);
   assign v_up   = head.vertex - INDEX_BITS'(head.cols);
   assign v_diag = v_up - INDEX_BITS'(1);

   always_comb begin
      out_free     = !rsp_valid_ff || !rsp_stall;
      go           = !empty && out_free;
      // a new grid restarts the numbering before its first triangle
      kept_base    = (head.first && (phase_ff == PHASE_UPPER)) ? '0 : kept_ff;
      emit_upper   = 1'b0;
      emit_lower   = 1'b0;
      phase_in     = phase_ff;
      pop          = 1'b0;
      case (phase_ff)
         PHASE_UPPER: begin
            emit_upper = go && head.keep_upper;
            emit_lower = go && !head.keep_upper && head.keep_lower;
            if (go) begin
               if (head.keep_upper && head.keep_lower) begin
                  phase_in = PHASE_LOWER;
               end else begin
                  pop = 1'b1;
               end
            end
         end
         PHASE_LOWER: begin
            emit_lower = go;
            if (go) begin
               phase_in = PHASE_UPPER;
               pop      = 1'b1;
            end
         end
         default: begin
            phase_in = PHASE_UPPER;
         end
      endcase
      emit         = emit_upper || emit_lower;
      kept_in      = go ? kept_base + TRI_W'(emit) : kept_ff;
      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_UPPER;
         kept_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         kept_ff      <= kept_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         corner_a_ff   <= v_left;
         corner_b_ff   <= emit_upper ? head.vertex : v_up;
         corner_c_ff   <= emit_upper ? v_up : v_diag;
         tri_number_ff <= kept_base;
         last_ff       <= emit_lower || !head.keep_lower;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_corner_a     = corner_a_ff;
   assign rsp_corner_b     = corner_b_ff;
   assign rsp_corner_c     = corner_c_ff;
   assign rsp_tri_number   = tri_number_ff;
   assign rsp_last_of_item = last_ff;

endmodule

// File: src/terrain_grid_frustum_culler_unit.sv
// ----------------------------------------------------------------------------
// terrain_grid_frustum_culler_unit
// Culls height-field terrain vertices against six planes and emits the kept
// triangles of each completed grid cell.
//
//   port group   dir    handshake          beat
//   req_*        in     valid / stall      one vertex, Q12.4 position
//   rsp_*        out    valid / stall      one triangle, three corners
//   psel..       in     apb-style write    64-bit register, 8-byte stride
//
// a vertex is taken every cycle unless the work queue is full
// each kept triangle is one beat on the result port, so a vertex that
// keeps both triangles sends its upper and then its lower triangle
// a vertex passes stage 1, stage 2, stage 3, the work queue and the result register
// reset is synchronous; the row flag line is not cleared
// rsp_stall backs up into the four-entry queue, then into req_stall
// ----------------------------------------------------------------------------
module terrain_grid_frustum_culler_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [tgfc_pkg::POS_W-1:0]    req_pos_x,
   input  logic signed [tgfc_pkg::POS_W-1:0]    req_pos_y,
   input  logic signed [tgfc_pkg::POS_W-1:0]    req_pos_z,
   input  logic                                 req_first_of_grid,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [tgfc_pkg::INDEX_BITS-1:0]      rsp_corner_a,
   output logic [tgfc_pkg::INDEX_BITS-1:0]      rsp_corner_b,
   output logic [tgfc_pkg::INDEX_BITS-1:0]      rsp_corner_c,
   output logic [tgfc_pkg::TRI_W-1:0]           rsp_tri_number,
   output logic                                 rsp_last_of_item,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [tgfc_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [tgfc_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [tgfc_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready
);
   import tgfc_pkg::*;

   tgfc_cfg_type  cfg;
   tgfc_work_type push_data;
   tgfc_work_type head;
   logic          push, pop, q_full, q_empty;

   tgfc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tgfc_front u_front (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_pos_z         (req_pos_z),
      .req_first_of_grid (req_first_of_grid),
      .q_full            (q_full),
      .push              (push),
      .push_data         (push_data)
   );

   tgfc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .empty     (q_empty),
      .head      (head)
   );

   tgfc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .empty            (q_empty),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_corner_a     (rsp_corner_a),
      .rsp_corner_b     (rsp_corner_b),
      .rsp_corner_c     (rsp_corner_c),
      .rsp_tri_number   (rsp_tri_number),
      .rsp_last_of_item (rsp_last_of_item)
   );

endmodule

// File: src/tgfc_checker.sv
// ----------------------------------------------------------------------------
// tgfc_checker
// Port-level checks of the culler's result stream.
// ----------------------------------------------------------------------------
module tgfc_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic [tgfc_pkg::INDEX_BITS-1:0]      rsp_corner_a,
   input logic [tgfc_pkg::INDEX_BITS-1:0]      rsp_corner_b,
   input logic [tgfc_pkg::INDEX_BITS-1:0]      rsp_corner_c,
   input logic [tgfc_pkg::TRI_W-1:0]           rsp_tri_number,
   input logic                                 rsp_last_of_item
);
   import tgfc_pkg::*;

   logic pair_beat;

   assign pair_beat = rsp_valid && !rsp_stall && !rsp_last_of_item;

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat right after reset");

   a_stalled_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_corner_a)
         && $stable(rsp_corner_b) && $stable(rsp_corner_c)
         && $stable(rsp_tri_number) && $stable(rsp_last_of_item))
      else $error("stalled result beat changed");

   // upper triangle is followed at once by the lower one of the same cell
   a_pair_numbering: assert property (@(posedge clock) disable iff (reset)
      pair_beat |=> rsp_valid && (rsp_tri_number == $past(rsp_tri_number) + TRI_W'(1)))
      else $error("lower triangle not numbered after upper triangle");

   a_pair_corners: assert property (@(posedge clock) disable iff (reset)
      pair_beat |=> rsp_corner_a == $past(rsp_corner_a)
         && rsp_corner_b == $past(rsp_corner_c))
      else $error("lower triangle corners do not match upper triangle");

endmodule

bind terrain_grid_frustum_culler_unit tgfc_checker u_tgfc_checker (.*);
